// ===== hw/rtl/hmi_byte_command_and_frame_parser_unit_assert.svh =====
// Assertion macros shared by the byte command and frame parser RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef HMI_BYTE_COMMAND_AND_FRAME_PARSER_UNIT_ASSERT_SVH
`define HMI_BYTE_COMMAND_AND_FRAME_PARSER_UNIT_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define HMI_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define HMI_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/hmi_bcfp_pkg.sv =====
// Package for the byte command and frame parser: command byte codes, event codes,
// configuration register indexes and the control state type. No dependencies.
package hmi_bcfp_pkg;

    localparam int BUFFER_DEPTH = 64;
    localparam int LEN_W        = 7;
    localparam int CFG_INDEX_W  = 1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_START = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_END   = 1'b1;

    // Panel command bytes.
    localparam logic [7:0] BYTE_MODE_NEXT   = 8'h31;
    localparam logic [7:0] BYTE_PERIOD_TGL  = 8'h32;
    localparam logic [7:0] BYTE_VIEW_TGL    = 8'h33;
    localparam logic [7:0] BYTE_MEASURE     = 8'h34;
    localparam logic [7:0] BYTE_RESULT_PAGE = 8'h35;
    localparam logic [7:0] BYTE_WAVE_PAGE   = 8'h36;
    localparam logic [7:0] BYTE_CLEAR       = 8'h37;
    localparam logic [7:0] BYTE_SKIP        = 8'h65;
    localparam logic [7:0] BYTE_REPLY       = 8'h66;
    localparam logic [7:0] BYTE_FILL        = 8'hFF;

    localparam logic [2:0] SKIP_LEN  = 3'd6;
    localparam logic [2:0] REPLY_LEN = 3'd4;

    localparam logic [7:0] PAGE_RESULT = 8'd0;
    localparam logic [7:0] PAGE_WAVE   = 8'd1;
    localparam logic [7:0] PAGE_NONE   = 8'hFF;

    // Event codes.
    localparam logic [2:0] EV_MODE_NEXT   = 3'd0;
    localparam logic [2:0] EV_PERIOD_TGL  = 3'd1;
    localparam logic [2:0] EV_VIEW_TGL    = 3'd2;
    localparam logic [2:0] EV_MEASURE     = 3'd3;
    localparam logic [2:0] EV_RESULT_PAGE = 3'd4;
    localparam logic [2:0] EV_WAVE_PAGE   = 3'd5;
    localparam logic [2:0] EV_CLEAR       = 3'd6;
    localparam logic [2:0] EV_NONE        = 3'd0;

    localparam logic KIND_EVENT = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    typedef enum logic {
        S_IDLE,
        S_REPLAY
    } state_t;

endpackage

// ===== hw/rtl/hmi_bcfp_ram.sv =====
// Frame buffer memory for the parser: one write port, one read port with
// registered read data. Uses hmi_bcfp_pkg for the default depth.
module hmi_bcfp_ram #(
    parameter int DEPTH = hmi_bcfp_pkg::BUFFER_DEPTH
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [7:0]               wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [7:0]               rd_data
);
    import hmi_bcfp_pkg::*;

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/hmi_byte_command_and_frame_parser_unit.sv =====
// Top level of the byte command and frame parser: panel command decoding,
// frame assembly and frame replay. Uses hmi_bcfp_pkg and hmi_bcfp_ram.
//
//  channel | signals                                     | direction
//  --------+---------------------------------------------+----------
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data   | in
//  in      | in_valid, in_ready, rx_byte                 | in
//  out     | out_valid, out_ready, result_kind,          | out
//          | event_code, frame_data, frame_length, last  |
//
// A byte is taken while idle when the output register is free or being emptied.
// A completing end byte starts a replay of N bytes; one byte is read from the
// frame buffer each cycle while the output does not stall.
// No byte is taken during a replay. Output stalls hold the read pipeline in place.
// Reset clears all control state; the frame buffer needs no clearing.
`include "hmi_byte_command_and_frame_parser_unit_assert.svh"

module hmi_byte_command_and_frame_parser_unit #(
    parameter int BUFFER_DEPTH = hmi_bcfp_pkg::BUFFER_DEPTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [hmi_bcfp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                           cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [7:0]                           rx_byte,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 result_kind,
    output logic [2:0]                           event_code,
    output logic [7:0]                           frame_data,
    output logic [hmi_bcfp_pkg::LEN_W-1:0]       frame_length,
    output logic                                 last
);
    import hmi_bcfp_pkg::*;

    localparam int ADDR_W = $clog2(BUFFER_DEPTH);
    localparam int FILL_W = $clog2(BUFFER_DEPTH + 1);

    // Configuration registers.
    logic [7:0] start_byte_reg;
    logic [7:0] end_byte_reg;

    // Panel and frame state.
    state_t      state_reg, state_next;
    logic [2:0]  skip_count_reg, skip_count_next;
    logic [2:0]  reply_count_reg, reply_count_next;
    logic [7:0]  reply_page_reg, reply_page_next;
    logic        reply_ok_reg, reply_ok_next;
    logic [7:0]  current_page_reg, current_page_next;
    logic        in_frame_reg, in_frame_next;
    logic [FILL_W-1:0] fill_index_reg, fill_index_next;

    // Replay sequencer.
    logic [FILL_W-1:0] len_reg, len_next;
    logic [FILL_W-1:0] rd_idx_reg, rd_idx_next;
    logic              rd_pend_reg, rd_pend_next;
    logic              pend_last_reg, pend_last_next;

    // Output register.
    logic             out_valid_reg, out_valid_next;
    logic             kind_reg, kind_next;
    logic [2:0]       code_reg, code_next;
    logic [7:0]       data_reg, data_next;
    logic [LEN_W-1:0] length_reg, length_next;
    logic             last_reg, last_next;

    // Memory ports.
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [7:0]        rd_data;

    logic              accept;
    logic              out_free;
    logic              load;
    logic [FILL_W-1:0] fill_inc;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && out_free;
    assign accept    = in_valid && in_ready;
    assign fill_inc  = fill_index_reg + FILL_W'(1);
    assign load      = (state_reg == S_REPLAY) && rd_pend_reg && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= 8'd0;
            end_byte_reg   <= 8'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FRAME_START: start_byte_reg <= cfg_data;
                CFG_FRAME_END:   end_byte_reg   <= cfg_data;
                default:         start_byte_reg <= start_byte_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            skip_count_reg   <= 3'd0;
            reply_count_reg  <= 3'd0;
            reply_page_reg   <= PAGE_NONE;
            reply_ok_reg     <= 1'b0;
            current_page_reg <= PAGE_NONE;
            in_frame_reg     <= 1'b0;
            fill_index_reg   <= '0;
            len_reg          <= '0;
            rd_idx_reg       <= '0;
            rd_pend_reg      <= 1'b0;
            pend_last_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            skip_count_reg   <= skip_count_next;
            reply_count_reg  <= reply_count_next;
            reply_page_reg   <= reply_page_next;
            reply_ok_reg     <= reply_ok_next;
            current_page_reg <= current_page_next;
            in_frame_reg     <= in_frame_next;
            fill_index_reg   <= fill_index_next;
            len_reg          <= len_next;
            rd_idx_reg       <= rd_idx_next;
            rd_pend_reg      <= rd_pend_next;
            pend_last_reg    <= pend_last_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        code_reg   <= code_next;
        data_reg   <= data_next;
        length_reg <= length_next;
        last_reg   <= last_next;
    end

    always_comb
    begin
        logic       consumed;
        logic       ev_fire;
        logic [2:0] ev_code;
        logic [7:0] page_sel;
        logic       page_fire;

        consumed  = 1'b0;
        ev_fire   = 1'b0;
        ev_code   = EV_NONE;
        page_sel  = PAGE_NONE;
        page_fire = 1'b0;

        state_next        = state_reg;
        skip_count_next   = skip_count_reg;
        reply_count_next  = reply_count_reg;
        reply_page_next   = reply_page_reg;
        reply_ok_next     = reply_ok_reg;
        current_page_next = current_page_reg;
        in_frame_next     = in_frame_reg;
        fill_index_next   = fill_index_reg;
        len_next          = len_reg;
        rd_idx_next       = rd_idx_reg;
        rd_pend_next      = rd_pend_reg;
        pend_last_next    = pend_last_reg;

        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        code_next      = code_reg;
        data_next      = data_reg;
        length_next    = length_reg;
        last_next      = last_reg;

        wr_en   = 1'b0;
        wr_addr = fill_index_reg[ADDR_W-1:0];
        rd_en   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // Panel layer, only while no frame is open.
                    if (!in_frame_reg)
                    begin
                        consumed = 1'b1;
                        if (skip_count_reg != 3'd0)
                        begin
                            skip_count_next = skip_count_reg - 3'd1;
                        end
                        else if (reply_count_reg != 3'd0)
                        begin
                            if (reply_count_reg == REPLY_LEN)
                            begin
                                reply_page_next = rx_byte;
                            end
                            else if (rx_byte != BYTE_FILL)
                            begin
                                reply_ok_next = 1'b0;
                            end
                            reply_count_next = reply_count_reg - 3'd1;
                            if (reply_count_next == 3'd0 && reply_ok_next
                                && reply_page_next != current_page_reg)
                            begin
                                page_sel  = reply_page_next;
                                page_fire = 1'b1;
                            end
                        end
                        else
                        begin
                            case (rx_byte)
                                BYTE_MODE_NEXT:
                                begin
                                    ev_fire = 1'b1;
                                    ev_code = EV_MODE_NEXT;
                                end
                                BYTE_PERIOD_TGL:
                                begin
                                    ev_fire = 1'b1;
                                    ev_code = EV_PERIOD_TGL;
                                end
                                BYTE_VIEW_TGL:
                                begin
                                    ev_fire = 1'b1;
                                    ev_code = EV_VIEW_TGL;
                                end
                                BYTE_MEASURE:
                                begin
                                    ev_fire = 1'b1;
                                    ev_code = EV_MEASURE;
                                end
                                BYTE_RESULT_PAGE:
                                begin
                                    page_sel  = PAGE_RESULT;
                                    page_fire = 1'b1;
                                end
                                BYTE_WAVE_PAGE:
                                begin
                                    page_sel  = PAGE_WAVE;
                                    page_fire = 1'b1;
                                end
                                BYTE_CLEAR:
                                begin
                                    ev_fire = 1'b1;
                                    ev_code = EV_CLEAR;
                                end
                                BYTE_SKIP:
                                begin
                                    skip_count_next = SKIP_LEN;
                                end
                                BYTE_REPLY:
                                begin
                                    reply_count_next = REPLY_LEN;
                                    reply_ok_next    = 1'b1;
                                end
                                default:
                                begin
                                    consumed = 1'b0;
                                end
                            endcase
                        end
                    end

                    // A page id other than result or wave raises nothing.
                    if (page_fire)
                    begin
                        if (page_sel == PAGE_RESULT)
                        begin
                            current_page_next = PAGE_RESULT;
                            ev_fire           = 1'b1;
                            ev_code           = EV_RESULT_PAGE;
                        end
                        else if (page_sel == PAGE_WAVE)
                        begin
                            current_page_next = PAGE_WAVE;
                            ev_fire           = 1'b1;
                            ev_code           = EV_WAVE_PAGE;
                        end
                    end

                    if (ev_fire)
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = KIND_EVENT;
                        code_next      = ev_code;
                        data_next      = 8'd0;
                        length_next    = '0;
                        last_next      = 1'b1;
                    end

                    // Frame assembly.
                    if (!consumed)
                    begin
                        if (rx_byte == start_byte_reg)
                        begin
                            wr_en           = 1'b1;
                            wr_addr         = '0;
                            in_frame_next   = 1'b1;
                            fill_index_next = FILL_W'(1);
                        end
                        else if (in_frame_reg)
                        begin
                            wr_en = 1'b1;
                            if (rx_byte == end_byte_reg)
                            begin
                                in_frame_next   = 1'b0;
                                fill_index_next = '0;
                                len_next        = fill_inc;
                                rd_idx_next     = '0;
                                rd_pend_next    = 1'b0;
                                state_next      = S_REPLAY;
                            end
                            else if (fill_inc >= FILL_W'(BUFFER_DEPTH))
                            begin
                                // Buffer full without an end byte: drop the frame.
                                in_frame_next   = 1'b0;
                                fill_index_next = '0;
                            end
                            else
                            begin
                                fill_index_next = fill_inc;
                            end
                        end
                    end
                end
            end

            S_REPLAY:
            begin
                // One read in flight; a new read is issued as the pending one moves out.
                if (rd_idx_reg < len_reg && (!rd_pend_reg || load))
                begin
                    rd_en          = 1'b1;
                    rd_idx_next    = rd_idx_reg + FILL_W'(1);
                    rd_pend_next   = 1'b1;
                    pend_last_next = (rd_idx_reg + FILL_W'(1)) == len_reg;
                end
                else if (load)
                begin
                    rd_pend_next = 1'b0;
                end

                if (load)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_FRAME;
                    code_next      = EV_NONE;
                    data_next      = rd_data;
                    length_next    = LEN_W'(len_reg);
                    last_next      = pend_last_reg;
                    if (pend_last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    hmi_bcfp_ram #(
        .DEPTH (BUFFER_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (rx_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    assign out_valid    = out_valid_reg;
    assign result_kind  = kind_reg;
    assign event_code   = code_reg;
    assign frame_data   = data_reg;
    assign frame_length = length_reg;
    assign last         = last_reg;

    `HMI_ASSERT_ALWAYS(a_fill_in_range, fill_index_reg < FILL_W'(BUFFER_DEPTH),
        "fill index reached the buffer depth")
    `HMI_ASSERT_ALWAYS(a_fill_closed, in_frame_reg || fill_index_reg == '0,
        "fill index nonzero while no frame is open")
    `HMI_ASSERT_ALWAYS(a_pend_replay, !rd_pend_reg || state_reg == S_REPLAY,
        "read pending outside replay")
    `HMI_ASSERT_ALWAYS(a_rd_bound, state_reg != S_REPLAY || rd_idx_reg <= len_reg,
        "replay read index ran past the frame length")
    `HMI_ASSERT_NEXT(a_replay_done, load && pend_last_reg,
        state_reg == S_IDLE && out_valid_reg && last_reg,
        "replay did not end on the last frame byte")

endmodule

// ===== tb/tb_hmi_byte_command_and_frame_parser_unit.sv =====
// Self-checking testbench for the byte command and frame parser unit.
// Needs hmi_bcfp_pkg and the parser RTL; a class predicts panel events and replayed frames.
module tb_hmi_byte_command_and_frame_parser_unit;
    import hmi_bcfp_pkg::*;

    typedef struct packed {
        logic             kind;
        logic [2:0]       code;
        logic [7:0]       data;
        logic [LEN_W-1:0] len;
        logic             last;
    } parser_result_t;

    class panel_stream_decoder;
        parser_result_t owed_results[$];
        int unsigned    errors;
        logic [7:0]     start_byte;
        logic [7:0]     end_byte;
        logic [2:0]     skip_left;
        logic [2:0]     reply_left;
        logic [7:0]     reply_id;
        logic           reply_good;
        logic [7:0]     shown_page;
        logic           frame_open;
        int unsigned    fill;
        logic [7:0]     frame_buf[BUFFER_DEPTH];

        function new();
            errors     = 0;
            start_byte = 8'h00;
            end_byte   = 8'h00;
            skip_left  = '0;
            reply_left = '0;
            reply_id   = PAGE_NONE;
            reply_good = 1'b0;
            shown_page = PAGE_NONE;
            frame_open = 1'b0;
            fill       = 0;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [7:0] val);
            if (idx == CFG_FRAME_START)
                start_byte = val;
            else if (idx == CFG_FRAME_END)
                end_byte = val;
        endfunction

        function void push_event(logic [2:0] code);
            parser_result_t r;
            r = '{KIND_EVENT, code, 8'h00, '0, 1'b1};
            owed_results.push_back(r);
        endfunction

        function void show_page(logic [7:0] page);
            if (page == PAGE_RESULT)
            begin
                shown_page = PAGE_RESULT;
                push_event(EV_RESULT_PAGE);
            end
            else if (page == PAGE_WAVE)
            begin
                shown_page = PAGE_WAVE;
                push_event(EV_WAVE_PAGE);
            end
        endfunction

        // Called once per accepted input transaction.
        function void take_byte(logic [7:0] b);
            logic           taken;
            int unsigned    k;
            parser_result_t r;
            if (!frame_open)
            begin
                if (skip_left != 0)
                begin
                    skip_left--;
                    return;
                end
                if (reply_left != 0)
                begin
                    if (reply_left == REPLY_LEN)
                        reply_id = b;
                    else if (b != BYTE_FILL)
                        reply_good = 1'b0;
                    reply_left--;
                    if (reply_left == 0 && reply_good && reply_id != shown_page)
                        show_page(reply_id);
                    return;
                end
                taken = 1'b1;
                case (b)
                    BYTE_MODE_NEXT:   push_event(EV_MODE_NEXT);
                    BYTE_PERIOD_TGL:  push_event(EV_PERIOD_TGL);
                    BYTE_VIEW_TGL:    push_event(EV_VIEW_TGL);
                    BYTE_MEASURE:     push_event(EV_MEASURE);
                    BYTE_RESULT_PAGE: show_page(PAGE_RESULT);
                    BYTE_WAVE_PAGE:   show_page(PAGE_WAVE);
                    BYTE_CLEAR:       push_event(EV_CLEAR);
                    BYTE_SKIP:        skip_left = SKIP_LEN;
                    BYTE_REPLY:
                    begin
                        reply_left = REPLY_LEN;
                        reply_good = 1'b1;
                    end
                    default:          taken = 1'b0;
                endcase
                if (taken)
                    return;
            end
            // The start byte wins over the end byte, even when both are equal.
            if (b == start_byte)
            begin
                frame_open   = 1'b1;
                frame_buf[0] = b;
                fill         = 1;
                return;
            end
            if (!frame_open)
                return;
            frame_buf[fill] = b;
            fill++;
            if (b == end_byte)
            begin
                for (k = 0; k < fill; k++)
                begin
                    r = '{KIND_FRAME, EV_NONE, frame_buf[k], LEN_W'(fill), k == fill - 1};
                    owed_results.push_back(r);
                end
                frame_open = 1'b0;
                fill       = 0;
            end
            else if (fill >= BUFFER_DEPTH)
            begin
                frame_open = 1'b0;
                fill       = 0;
            end
        endfunction

        function void match_result(parser_result_t got);
            parser_result_t want;
            if (owed_results.size() == 0)
            begin
                $error("result with none owed: kind %0d code %0d data 0x%02h length %0d last %0d",
                       got.kind, got.code, got.data, got.len, got.last);
                errors++;
                return;
            end
            want = owed_results.pop_front();
            if (got.kind != want.kind)
            begin
                $error("result_kind: expected %0d, actual %0d", want.kind, got.kind);
                errors++;
            end
            if (got.code != want.code)
            begin
                $error("event_code: expected %0d, actual %0d", want.code, got.code);
                errors++;
            end
            if (got.data != want.data)
            begin
                $error("frame_data: expected 0x%02h, actual 0x%02h", want.data, got.data);
                errors++;
            end
            if (got.len != want.len)
            begin
                $error("frame_length: expected %0d, actual %0d", want.len, got.len);
                errors++;
            end
            if (got.last != want.last)
            begin
                $error("last: expected %0d, actual %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_FRAME_START;
    logic [7:0]             cfg_data = 8'h00;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [7:0]             rx_byte = 8'h00;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   result_kind;
    logic [2:0]             event_code;
    logic [7:0]             frame_data;
    logic [LEN_W-1:0]       frame_length;
    logic                   last;

    panel_stream_decoder decoder = new();

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned bytes_sent = 0;
    bit          hold_request = 1'b0;

    hmi_byte_command_and_frame_parser_unit i_dut (.*);

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Output side: random stalls, plus a long hold-off whenever one is requested.
    initial
    begin : receiver
        int unsigned hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = 300;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Handshakes are judged at the falling edge, where every signal is settled.
    initial
    begin : result_monitor
        parser_result_t seen;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                seen = '{result_kind, event_code, frame_data, frame_length, last};
                decoder.match_result(seen);
            end
        end
    end

    // Entered and left at a rising edge; valid stays high into the next byte unless a gap falls.
    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(negedge clk);
        while (!in_ready);
        decoder.take_byte(b);
        bytes_sent++;
        @(posedge clk);
    endtask

    task automatic configure(input logic [7:0] start_val, input logic [7:0] end_val);
        logic [7:0] vals[2];
        int         i;
        vals[CFG_FRAME_START] = start_val;
        vals[CFG_FRAME_END]   = end_val;
        for (i = 0; i < 2; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_INDEX_W'(i);
            cfg_data  <= vals[i];
            do
                @(negedge clk);
            while (!cfg_ready);
            @(posedge clk);
            decoder.write_register(CFG_INDEX_W'(i), vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // Stop sending and wait until every owed result is out; a byte that makes no
    // result may still be in the pipeline, so the task goes on waiting after that.
    task automatic settle();
        in_valid <= 1'b0;
        while (decoder.owed_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic send_frame(input int unsigned body_len, input bit close);
        logic [7:0]  b;
        int unsigned k;
        send_byte(decoder.start_byte);
        for (k = 0; k < body_len; k++)
        begin
            b = 8'($urandom);
            if ($urandom_range(15) != 0)
                while (b == decoder.start_byte || b == decoder.end_byte)
                    b = 8'($urandom);
            send_byte(b);
        end
        if (close)
            send_byte(decoder.end_byte);
    endtask

    task automatic random_traffic(input int unsigned budget);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned k;
        logic [7:0]  id;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 15)
            begin
                send_byte(BYTE_MODE_NEXT + 8'($urandom_range(6)));
            end
            else if (pick < 22)
            begin
                send_byte(BYTE_SKIP);
                for (k = 0; k < SKIP_LEN; k++)
                    send_byte(8'($urandom));
            end
            else if (pick < 36)
            begin
                case ($urandom_range(3))
                    0:       id = PAGE_RESULT;
                    1:       id = PAGE_WAVE;
                    2:       id = PAGE_NONE;
                    default: id = 8'($urandom);
                endcase
                send_byte(BYTE_REPLY);
                send_byte(id);
                for (k = 1; k < REPLY_LEN; k++)
                    send_byte(($urandom_range(5) == 0) ? 8'($urandom) : BYTE_FILL);
            end
            else if (pick < 92)
            begin
                // Mostly short frames; now and then one just under, at or just past the buffer size.
                if ($urandom_range(24) == 0)
                    send_frame($urandom_range(BUFFER_DEPTH - 3, BUFFER_DEPTH - 1),
                               $urandom_range(9) != 0);
                else
                    send_frame($urandom_range(0, 8), $urandom_range(9) != 0);
            end
            else
            begin
                send_byte(8'($urandom));
            end
        end
    endtask

    initial
    begin : main
        logic [7:0] opening[$];
        opening = '{BYTE_MODE_NEXT, BYTE_PERIOD_TGL, BYTE_VIEW_TGL, BYTE_MEASURE,
                    BYTE_RESULT_PAGE, BYTE_RESULT_PAGE, BYTE_WAVE_PAGE, BYTE_CLEAR,
                    BYTE_SKIP, BYTE_CLEAR, BYTE_REPLY, 8'hAA, 8'h00, 8'hFF, BYTE_MODE_NEXT,
                    BYTE_REPLY, PAGE_RESULT, BYTE_FILL, BYTE_FILL, BYTE_FILL,
                    BYTE_REPLY, PAGE_WAVE, BYTE_FILL, 8'h12, BYTE_FILL,
                    8'hAA, BYTE_MODE_NEXT, 8'hAA, 8'h55};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        configure(8'hAA, 8'h55);
        foreach (opening[i])
            send_byte(opening[i]);
        settle();

        // Extreme register values; the output is held off so the input backs up.
        configure(8'h00, 8'hFF);
        hold_request = 1'b1;
        send_frame(BUFFER_DEPTH - 2, 1'b1);
        send_frame(BUFFER_DEPTH - 1, 1'b1);
        random_traffic(60);
        settle();

        configure(8'hFF, 8'h00);
        send_idle_pct = 73;
        random_traffic(50);
        settle();

        // Equal start and end bytes: the end byte always restarts the frame.
        configure(8'h7E, 8'h7E);
        send_idle_pct = 0;
        stall_pct     = 73;
        random_traffic(60);
        settle();

        configure(8'h3C, 8'h3E);
        send_idle_pct = 35;
        stall_pct     = 35;
        random_traffic(50);
        settle();
        random_traffic(50);
        settle();

        configure(8'($urandom), 8'($urandom));
        send_idle_pct = 0;
        stall_pct     = 0;
        random_traffic(30);
        settle();

        if (decoder.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
